[rtl/core/xcs_pkg.sv]
package xcs_pkg;

  localparam int unsigned HdrLen       = 12;
  localparam int unsigned MagicLen     = 18;
  localparam int unsigned CookieLen    = 16;
  localparam int unsigned MaxNameBytes = 24;
  localparam int unsigned MaxDataBytes = 16;
  localparam int unsigned NameLenPos   = 6;
  localparam int unsigned DataLenPos   = 8;
  localparam int unsigned CmdFifoDepth = 4;
  localparam int unsigned AddrW        = 6;
  localparam int unsigned CfgDataW     = 64;
  localparam int unsigned BurstW       = $clog2(HdrLen + MaxNameBytes + MaxDataBytes + 1);

  localparam logic [7:0] BomMsb = 8'h42;
  localparam logic [7:0] BomLsb = 8'h6C;

  typedef enum logic [2:0] {
    RegFakeLow,
    RegFakeHigh,
    RegDataLow,
    RegDataHigh,
    RegName0,
    RegName1,
    RegName2,
    RegLengths
  } reg_idx_e;

  typedef enum logic [1:0] {
    CmdPass,
    CmdClose,
    CmdRebuild
  } cmd_kind_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       from_remote;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_of_run;
    logic       close_channel;
  } out_item_t;

  typedef struct packed {
    cmd_kind_e  kind;
    logic [7:0] data;
  } cmd_t;

  typedef logic [HdrLen-1:0][7:0] hdr_t;

  typedef struct packed {
    logic [CookieLen-1:0][7:0]    fake_cookie;
    logic [MaxDataBytes-1:0][7:0] real_data;
    logic [MaxNameBytes-1:0][7:0] real_name;
    logic [9:0]                   real_lengths;
  } cfg_t;

endpackage

[rtl/core/x11_setup_cookie_swap.sv]
// A result is registered in the command queue and then in the output register after its
// input beat is accepted, and is held back longer while earlier results wait.
// Throughput: one input beat and one result beat per cycle while results are popped;
// the rebuilt packet is a burst of 12 to 52 result beats from one input beat, paced by
// the output register, and input stalls once the command queue fills behind the burst.
// Reset (asynchronous, active low) clears the parse counters and phase, empties the
// command queue and the output register, and clears all configuration registers to zero.
module x11_setup_cookie_swap #(
  parameter int unsigned CmdDepth = xcs_pkg::CmdFifoDepth
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [xcs_pkg::AddrW-1:0]    paddr,
  input  logic [xcs_pkg::CfgDataW-1:0] pwdata,
  output logic [xcs_pkg::CfgDataW-1:0] prdata,
  output logic                         pready,
  input  logic                         push,
  output logic                         full,
  input  xcs_pkg::in_item_t            in_item_i,
  output logic                         empty,
  input  logic                         pop,
  output xcs_pkg::out_item_t           out_item_o
);

  xcs_pkg::cfg_t cfg;
  xcs_pkg::hdr_t hdr;
  xcs_pkg::cmd_t cmd_in, cmd_out;
  logic          accept, cmd_push, cmd_full, cmd_pop, cmd_empty;

  assign full   = cmd_full;
  assign accept = push && !cmd_full;

  xcs_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  xcs_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .item_i      (in_item_i),
    .cfg_i       (cfg),
    .cmd_valid_o (cmd_push),
    .cmd_o       (cmd_in),
    .hdr_o       (hdr)
  );

  xcs_cmd_fifo #(
    .Depth (CmdDepth)
  ) u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .data_i  (cmd_in),
    .full_o  (cmd_full),
    .pop_i   (cmd_pop),
    .data_o  (cmd_out),
    .empty_o (cmd_empty)
  );

  xcs_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (!cmd_empty),
    .cmd_i       (cmd_out),
    .cmd_pop_o   (cmd_pop),
    .hdr_i       (hdr),
    .cfg_i       (cfg),
    .pop_i       (pop),
    .empty_o     (empty),
    .item_o      (out_item_o)
  );

  // The front only issues a command for a beat it accepted, so the queue never overflows.
  assert property (@(posedge clk_i) disable iff (!rst_ni) cmd_push |-> !cmd_full)
    else $error("command issued while queue full");

  // A close result carries a zero byte and ends its run.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && out_item_o.close_channel) |->
      (out_item_o.out_byte == 8'h00 && out_item_o.last_of_run))
    else $error("malformed close result");

  // Inside a rebuilt-packet burst the next beat is always ready behind the current one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !out_item_o.last_of_run) |=> !empty)
    else $error("gap inside rebuilt packet burst");

  assert property (@(posedge clk_i) disable iff (!rst_ni) $rose(rst_ni) |-> empty)
    else $error("result present right after reset");

endmodule

[rtl/core/xcs_regs.sv]
module xcs_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [xcs_pkg::AddrW-1:0]     paddr,
  input  logic [xcs_pkg::CfgDataW-1:0]  pwdata,
  output logic [xcs_pkg::CfgDataW-1:0]  prdata,
  output logic                          pready,
  output xcs_pkg::cfg_t                 cfg_o
);

  logic [xcs_pkg::CfgDataW-1:0] fake_lo_q, fake_hi_q, data_lo_q, data_hi_q;
  logic [xcs_pkg::CfgDataW-1:0] name0_q, name1_q, name2_q;
  logic [9:0]                   lengths_q;
  logic                         wr_en;
  xcs_pkg::reg_idx_e            idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = xcs_pkg::reg_idx_e'(paddr[xcs_pkg::AddrW-1:3]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fake_lo_q <= '0;
      fake_hi_q <= '0;
      data_lo_q <= '0;
      data_hi_q <= '0;
      name0_q   <= '0;
      name1_q   <= '0;
      name2_q   <= '0;
      lengths_q <= '0;
    end else if (wr_en) begin
      unique case (idx)
        xcs_pkg::RegFakeLow:  fake_lo_q <= pwdata;
        xcs_pkg::RegFakeHigh: fake_hi_q <= pwdata;
        xcs_pkg::RegDataLow:  data_lo_q <= pwdata;
        xcs_pkg::RegDataHigh: data_hi_q <= pwdata;
        xcs_pkg::RegName0:    name0_q   <= pwdata;
        xcs_pkg::RegName1:    name1_q   <= pwdata;
        xcs_pkg::RegName2:    name2_q   <= pwdata;
        xcs_pkg::RegLengths:  lengths_q <= pwdata[9:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      xcs_pkg::RegFakeLow:  prdata = fake_lo_q;
      xcs_pkg::RegFakeHigh: prdata = fake_hi_q;
      xcs_pkg::RegDataLow:  prdata = data_lo_q;
      xcs_pkg::RegDataHigh: prdata = data_hi_q;
      xcs_pkg::RegName0:    prdata = name0_q;
      xcs_pkg::RegName1:    prdata = name1_q;
      xcs_pkg::RegName2:    prdata = name2_q;
      xcs_pkg::RegLengths:  prdata = {{(xcs_pkg::CfgDataW-10){1'b0}}, lengths_q};
      default:              prdata = '0;
    endcase
  end

  assign cfg_o.fake_cookie  = {fake_hi_q, fake_lo_q};
  assign cfg_o.real_data    = {data_hi_q, data_lo_q};
  assign cfg_o.real_name    = {name2_q, name1_q, name0_q};
  assign cfg_o.real_lengths = lengths_q;

endmodule

[rtl/core/xcs_front.sv]
module xcs_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  xcs_pkg::in_item_t item_i,
  input  xcs_pkg::cfg_t     cfg_i,
  output logic              cmd_valid_o,
  output xcs_pkg::cmd_t     cmd_o,
  output xcs_pkg::hdr_t     hdr_o
);

  localparam logic [1:0] PhCollect = 2'd0;
  localparam logic [1:0] PhPass    = 2'd1;
  localparam logic [1:0] PhClosed  = 2'd2;

  localparam int unsigned MagicEnd    = xcs_pkg::HdrLen + xcs_pkg::MagicLen;
  localparam int unsigned CookieStart = xcs_pkg::HdrLen + ((xcs_pkg::MagicLen + 3) / 4) * 4;
  localparam int unsigned CookieEnd   = CookieStart + xcs_pkg::CookieLen;
  localparam logic [xcs_pkg::MagicLen-1:0][7:0] MagicStr = "MIT-MAGIC-COOKIE-1";

  logic [1:0]    phase_q, phase_d;
  logic [17:0]   cnt_q, cnt_d;
  logic [17:0]   tot_q, tot_d;
  logic [17:0]   end_q, end_d;
  logic          lok_q, lok_d;
  logic          mis_q, mis_d;
  xcs_pkg::hdr_t hdr_q, hdr_d;

  logic          lo_first;
  logic [15:0]   nlen, dlen;
  logic [4:0]    moff;
  logic [4:0]    magic_idx;
  logic [7:0]    magic_byte;
  logic [3:0]    coff;

  function automatic logic [16:0] pad4(input logic [15:0] n);
    return ({1'b0, n} + 17'd3) & 17'h1FFFC;
  endfunction

  // Lengths are taken from the header one byte early so the end offset is ready in time.
  assign lo_first = hdr_q[0] != xcs_pkg::BomMsb;
  assign nlen = lo_first ? {hdr_q[xcs_pkg::NameLenPos+1], hdr_q[xcs_pkg::NameLenPos]}
                         : {hdr_q[xcs_pkg::NameLenPos], hdr_q[xcs_pkg::NameLenPos+1]};
  assign dlen = lo_first ? {hdr_q[xcs_pkg::DataLenPos+1], hdr_q[xcs_pkg::DataLenPos]}
                         : {hdr_q[xcs_pkg::DataLenPos], hdr_q[xcs_pkg::DataLenPos+1]};

  // The first character of the name sits in the top byte of the string constant.
  assign moff       = cnt_q[4:0] - 5'(xcs_pkg::HdrLen);
  assign magic_idx  = 5'(xcs_pkg::MagicLen - 1) - moff;
  assign magic_byte = MagicStr[magic_idx];
  assign coff       = 4'(cnt_q - 18'(CookieStart));

  always_comb begin
    phase_d     = phase_q;
    cnt_d       = cnt_q;
    tot_d       = tot_q;
    end_d       = end_q;
    lok_d       = lok_q;
    mis_d       = mis_q;
    hdr_d       = hdr_q;
    cmd_valid_o = 1'b0;
    cmd_o.kind  = xcs_pkg::CmdPass;
    cmd_o.data  = item_i.data_byte;
    if (accept_i) begin
      if (!item_i.from_remote) begin
        cmd_valid_o = 1'b1;
      end else begin
        unique case (phase_q)
          PhPass: begin
            cmd_valid_o = 1'b1;
          end
          PhCollect: begin
            cnt_d = cnt_q + 18'd1;
            if (cnt_q < 18'(xcs_pkg::HdrLen)) begin
              hdr_d[cnt_q[3:0]] = item_i.data_byte;
            end
            if (cnt_q == 18'(xcs_pkg::HdrLen - 2)) begin
              tot_d = 18'(pad4(nlen)) + 18'(pad4(dlen));
              lok_d = (nlen == 16'(xcs_pkg::MagicLen)) && (dlen == 16'(xcs_pkg::CookieLen));
            end
            // Fixed offsets suffice: with any other lengths the mismatch is already set.
            if (cnt_q >= 18'(xcs_pkg::HdrLen) && cnt_q < 18'(MagicEnd) &&
                item_i.data_byte != magic_byte) begin
              mis_d = 1'b1;
            end
            if (cnt_q >= 18'(CookieStart) && cnt_q < 18'(CookieEnd) &&
                item_i.data_byte != cfg_i.fake_cookie[coff]) begin
              mis_d = 1'b1;
            end
            if (cnt_q == 18'(xcs_pkg::HdrLen - 1)) begin
              if (hdr_q[0] != xcs_pkg::BomMsb && hdr_q[0] != xcs_pkg::BomLsb) begin
                cmd_valid_o = 1'b1;
                cmd_o.kind  = xcs_pkg::CmdClose;
                phase_d     = PhClosed;
              end else begin
                if (!lok_q) begin
                  mis_d = 1'b1;
                end
                end_d = 18'(xcs_pkg::HdrLen) + tot_q;
                if (tot_q == '0) begin
                  cmd_valid_o = 1'b1;
                  cmd_o.kind  = xcs_pkg::CmdClose;
                  phase_d     = PhClosed;
                end
              end
            end else if (cnt_q >= 18'(xcs_pkg::HdrLen) && cnt_d == end_q) begin
              cmd_valid_o = 1'b1;
              if (mis_d) begin
                cmd_o.kind = xcs_pkg::CmdClose;
                phase_d    = PhClosed;
              end else begin
                cmd_o.kind = xcs_pkg::CmdRebuild;
                phase_d    = PhPass;
              end
            end
          end
          PhClosed: ;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhCollect;
      cnt_q   <= '0;
      tot_q   <= '0;
      end_q   <= '0;
      lok_q   <= 1'b0;
      mis_q   <= 1'b0;
    end else begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      tot_q   <= tot_d;
      end_q   <= end_d;
      lok_q   <= lok_d;
      mis_q   <= mis_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hdr_q <= hdr_d;
  end

  assign hdr_o = hdr_q;

endmodule

[rtl/core/xcs_cmd_fifo.sv]
module xcs_cmd_fifo #(
  parameter int unsigned Depth = xcs_pkg::CmdFifoDepth
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  xcs_pkg::cmd_t data_i,
  output logic          full_o,
  input  logic          pop_i,
  output xcs_pkg::cmd_t data_o,
  output logic          empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  xcs_pkg::cmd_t   mem_q [Depth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;
  logic            do_wr, do_rd;

  assign full_o  = cnt_q == CntW'(Depth);
  assign empty_o = cnt_q == '0;
  assign do_wr   = push_i && !full_o;
  assign do_rd   = pop_i && !empty_o;
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_wr) begin
        wr_q <= (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + PtrW'(1);
      end
      if (do_rd) begin
        rd_q <= (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + PtrW'(1);
      end
      if (do_wr && !do_rd) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (do_rd && !do_wr) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

[rtl/core/xcs_back.sv]
module xcs_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cmd_valid_i,
  input  xcs_pkg::cmd_t      cmd_i,
  output logic               cmd_pop_o,
  input  xcs_pkg::hdr_t      hdr_i,
  input  xcs_pkg::cfg_t      cfg_i,
  input  logic               pop_i,
  output logic               empty_o,
  output xcs_pkg::out_item_t item_o
);

  localparam int unsigned KW = xcs_pkg::BurstW;

  logic               busy_q, busy_d;
  logic [KW-1:0]      k_q, k_d;
  logic               out_valid_q, out_valid_d;
  xcs_pkg::out_item_t out_q, out_d;

  logic [4:0]    nl_raw, dl_raw, nl, dl;
  logic [KW-1:0] pn, pd, n, k, i, j;
  logic          lo_first, burst_last, adv;
  logic [7:0]    pb;

  assign nl_raw = cfg_i.real_lengths[4:0];
  assign dl_raw = cfg_i.real_lengths[9:5];
  assign nl = (nl_raw > 5'(xcs_pkg::MaxNameBytes)) ? 5'(xcs_pkg::MaxNameBytes) : nl_raw;
  assign dl = (dl_raw > 5'(xcs_pkg::MaxDataBytes)) ? 5'(xcs_pkg::MaxDataBytes) : dl_raw;
  assign pn = (KW'(nl) + KW'(3)) & ~KW'(3);
  assign pd = (KW'(dl) + KW'(3)) & ~KW'(3);
  assign n  = KW'(xcs_pkg::HdrLen) + pn + pd;

  assign k          = busy_q ? k_q : '0;
  assign i          = k - KW'(xcs_pkg::HdrLen);
  assign j          = i - pn;
  assign lo_first   = hdr_i[0] != xcs_pkg::BomMsb;
  assign burst_last = (k_q + KW'(1)) == n;

  // Byte k of the rebuilt packet: header with local lengths, then padded name and data.
  always_comb begin
    pb = 8'h00;
    if (k < KW'(xcs_pkg::HdrLen)) begin
      pb = hdr_i[k[3:0]];
      if (k == KW'(xcs_pkg::NameLenPos)) begin
        pb = lo_first ? 8'(nl) : 8'h00;
      end
      if (k == KW'(xcs_pkg::NameLenPos + 1)) begin
        pb = lo_first ? 8'h00 : 8'(nl);
      end
      if (k == KW'(xcs_pkg::DataLenPos)) begin
        pb = lo_first ? 8'(dl) : 8'h00;
      end
      if (k == KW'(xcs_pkg::DataLenPos + 1)) begin
        pb = lo_first ? 8'h00 : 8'(dl);
      end
    end else if (i < pn) begin
      if (i < KW'(nl)) begin
        pb = cfg_i.real_name[i[4:0]];
      end
    end else if (j < KW'(dl)) begin
      pb = cfg_i.real_data[j[3:0]];
    end
  end

  assign adv = !out_valid_q || pop_i;

  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    busy_d      = busy_q;
    k_d         = k_q;
    cmd_pop_o   = 1'b0;
    if (adv) begin
      out_valid_d = 1'b0;
      if (busy_q) begin
        out_valid_d         = 1'b1;
        out_d.out_byte      = pb;
        out_d.last_of_run   = burst_last;
        out_d.close_channel = 1'b0;
        k_d                 = k_q + KW'(1);
        busy_d              = !burst_last;
      end else if (cmd_valid_i) begin
        cmd_pop_o   = 1'b1;
        out_valid_d = 1'b1;
        unique case (cmd_i.kind)
          xcs_pkg::CmdClose: begin
            out_d.out_byte      = 8'h00;
            out_d.last_of_run   = 1'b1;
            out_d.close_channel = 1'b1;
          end
          xcs_pkg::CmdRebuild: begin
            out_d.out_byte      = pb;
            out_d.last_of_run   = 1'b0;
            out_d.close_channel = 1'b0;
            busy_d              = 1'b1;
            k_d                 = KW'(1);
          end
          default: begin
            out_d.out_byte      = cmd_i.data;
            out_d.last_of_run   = 1'b1;
            out_d.close_channel = 1'b0;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      k_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      k_q         <= k_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign empty_o = !out_valid_q;
  assign item_o  = out_q;

endmodule
